>>> rtl/core/udm_pkg.sv
package udm_pkg;

    // dividends for the two leading divisions, 33 bits msb first
    localparam logic [32:0] DIV_TWO32   = 33'h1_0000_0000;
    localparam logic [32:0] DIV_TWO31M1 = 33'h0_7FFF_FFFF;

    localparam logic [31:0] TWO31       = 32'h8000_0000;
    localparam logic [31:0] TWO31M1     = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [6:0]  P_START     = 7'd31;
    localparam logic [6:0]  P_LIMIT     = 7'd64;
    localparam logic [6:0]  P_BASE      = 7'd32;
    localparam int unsigned DIV_STEPS   = 33;
    localparam int unsigned ITER_STEPS  = 33;

    // one request inside the long division stages
    typedef struct packed {
        logic        vld;
        logic [31:0] d;
        logic [31:0] ra;   // running remainder of 2^32 by d
        logic [31:0] rb;   // running remainder of 2^31-1 by d
        logic [31:0] qb;   // running quotient of 2^31-1 by d
    } udm_div_t;

    // one request inside the doubling stages
    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        done;
        logic        add;
        logic [6:0]  p;
        logic [31:0] d;
        logic [31:0] nc;
        logic [31:0] q1;
        logic [31:0] r1;
        logic [31:0] q2;
        logic [31:0] r2;
    } udm_iter_t;

endpackage

>>> rtl/core/udiv32_magic_number_gen.sv
// channel  | ports                                          | dir
// ---------+------------------------------------------------+-----
// request  | s_valid s_ready s_divisor                      | in
// result   | m_valid m_ready m_valid_res m_multiplier       | out
//          | m_post_shift m_add_form                        |
//
// pipeline: request register, 33 long division stages, one setup stage for nc,
// 33 doubling stages and the output register; one request enters per cycle when
// not stalled; the whole pipeline moves only when the output register is empty
// or taken, so a stall freezes every stage and nothing is lost or repeated
// synchronous active-low reset clears the valid bits of every stage
module udiv32_magic_number_gen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_divisor,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [31:0] m_multiplier,
    output logic [5:0]  m_post_shift,
    output logic        m_add_form
);
    import udm_pkg::*;

    // global advance: output register empty or being drained
    logic en;

    udm_div_t  dv_reg [0:DIV_STEPS];
    udm_iter_t it_reg [0:ITER_STEPS];
    udm_iter_t it_next;

    logic        m_valid_reg;
    logic        m_valid_res_reg;
    logic [31:0] m_multiplier_reg;
    logic [5:0]  m_post_shift_reg;
    logic        m_add_form_reg;

    logic [5:0]  shift_raw;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // request capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0].vld <= 1'b0;
        end else if (en) begin
            dv_reg[0].vld <= s_valid;
            dv_reg[0].d   <= s_divisor;
            dv_reg[0].ra  <= 32'd0;
            dv_reg[0].rb  <= 32'd0;
            dv_reg[0].qb  <= 32'd0;
        end
    end

    // restoring division, one dividend bit per stage, both dividends share d
    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_div
            logic [32:0] ta;
            logic [32:0] tb;
            udm_div_t    nx;
            always_comb begin
                ta = {dv_reg[k].ra, DIV_TWO32[DIV_STEPS-1-k]};
                tb = {dv_reg[k].rb, DIV_TWO31M1[DIV_STEPS-1-k]};
                nx = dv_reg[k];
                if (ta >= {1'b0, dv_reg[k].d}) begin
                    nx.ra = 32'(ta - {1'b0, dv_reg[k].d});
                end else begin
                    nx.ra = ta[31:0];
                end
                if (tb >= {1'b0, dv_reg[k].d}) begin
                    nx.rb = 32'(tb - {1'b0, dv_reg[k].d});
                    nx.qb = {dv_reg[k].qb[30:0], 1'b1};
                end else begin
                    nx.rb = tb[31:0];
                    nx.qb = {dv_reg[k].qb[30:0], 1'b0};
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_reg[k+1].vld <= 1'b0;
                end else if (en) begin
                    dv_reg[k+1] <= nx;
                end
            end
        end
    endgenerate

    // setup: nc is never below 2^31, so 2^31 / nc is 1 only when nc is 2^31
    always_comb begin
        it_next.vld  = dv_reg[DIV_STEPS].vld;
        it_next.d    = dv_reg[DIV_STEPS].d;
        it_next.ok   = (dv_reg[DIV_STEPS].d >= 32'd2);
        it_next.done = !it_next.ok;   // divisor below two skips the search
        it_next.add  = 1'b0;
        it_next.p    = P_START;
        it_next.nc   = ALL_ONES - dv_reg[DIV_STEPS].ra;
        it_next.q1   = {31'd0, (it_next.nc == TWO31)};
        it_next.r1   = (it_next.nc == TWO31) ? 32'd0 : TWO31;
        it_next.q2   = dv_reg[DIV_STEPS].qb;
        it_next.r2   = dv_reg[DIV_STEPS].rb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_reg[0].vld <= 1'b0;
        end else if (en) begin
            it_reg[0] <= it_next;
        end
    end

    // one doubling step per stage, finished requests pass through unchanged
    generate
        for (k = 0; k < ITER_STEPS; k++) begin : g_iter
            udm_step u_step (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .in_st   (it_reg[k]),
                .out_reg (it_reg[k+1])
            );
        end
    endgenerate

    // result forming
    assign shift_raw = 6'(it_reg[ITER_STEPS].p - P_BASE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= it_reg[ITER_STEPS].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (it_reg[ITER_STEPS].ok) begin
                m_valid_res_reg  <= 1'b1;
                m_multiplier_reg <= it_reg[ITER_STEPS].q2 + 32'd1;
                m_add_form_reg   <= it_reg[ITER_STEPS].add;
                if (it_reg[ITER_STEPS].add && (shift_raw != 6'd0)) begin
                    m_post_shift_reg <= shift_raw - 6'd1;
                end else begin
                    m_post_shift_reg <= shift_raw;
                end
            end else begin
                m_valid_res_reg  <= 1'b0;
                m_multiplier_reg <= 32'd0;
                m_add_form_reg   <= 1'b0;
                m_post_shift_reg <= 6'd0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_multiplier = m_multiplier_reg;
    assign m_post_shift = m_post_shift_reg;
    assign m_add_form   = m_add_form_reg;

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |->
            (m_multiplier == 32'd0 && m_post_shift == 6'd0 && !m_add_form))
        else $error("rejected divisor gave nonzero result fields");
    a_add_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_add_form) |-> m_valid_res)
        else $error("add form flagged for rejected divisor");
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_post_shift <= 6'd32))
        else $error("post shift out of range");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && it_reg[ITER_STEPS].vld) |=> it_reg[ITER_STEPS].vld)
        else $error("last doubling stage lost a request during a stall");
`endif

endmodule

>>> rtl/core/udm_step.sv
module udm_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  udm_pkg::udm_iter_t in_st,
    output udm_pkg::udm_iter_t out_reg
);
    import udm_pkg::*;

    udm_iter_t   out_next;
    logic [32:0] r1_dbl;
    logic [32:0] r2_dbl;
    logic [31:0] q1_n;
    logic [31:0] r1_n;
    logic [31:0] q2_n;
    logic [31:0] r2_n;
    logic [31:0] delta;
    logic [6:0]  p_n;
    logic        add_n;

    always_comb begin
        r1_dbl = {in_st.r1, 1'b0};
        r2_dbl = {in_st.r2, 1'b1};
        add_n  = in_st.add;
        if ({1'b0, in_st.r1} >= ({1'b0, in_st.nc} - {1'b0, in_st.r1})) begin
            q1_n = {in_st.q1[30:0], 1'b1};
            r1_n = 32'(r1_dbl - {1'b0, in_st.nc});
        end else begin
            q1_n = {in_st.q1[30:0], 1'b0};
            r1_n = r1_dbl[31:0];
        end
        if (({1'b0, in_st.r2} + 33'd1) >= ({1'b0, in_st.d} - {1'b0, in_st.r2})) begin
            if (in_st.q2 >= TWO31M1) begin
                add_n = 1'b1;
            end
            q2_n = {in_st.q2[30:0], 1'b1};
            r2_n = 32'(r2_dbl - {1'b0, in_st.d});
        end else begin
            if (in_st.q2 >= TWO31) begin
                add_n = 1'b1;
            end
            q2_n = {in_st.q2[30:0], 1'b0};
            r2_n = r2_dbl[31:0];
        end
        delta = in_st.d - 32'd1 - r2_n;
        p_n   = in_st.p + 7'd1;

        out_next = in_st;
        if (!in_st.done) begin
            out_next.q1   = q1_n;
            out_next.r1   = r1_n;
            out_next.q2   = q2_n;
            out_next.r2   = r2_n;
            out_next.p    = p_n;
            out_next.add  = add_n;
            out_next.done = !((p_n < P_LIMIT) &&
                              ((q1_n < delta) || ((q1_n == delta) && (r1_n == 32'd0))));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> verif/tb_udiv32_magic_number_gen.sv
`timescale 1ns / 100ps

module tb_udiv32_magic_number_gen;

    // clock, reset and dut ports
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_divisor;
    logic        m_valid;
    logic        m_ready;
    logic        m_valid_res;
    logic [31:0] m_multiplier;
    logic [5:0]  m_post_shift;
    logic        m_add_form;

    // one expected magic number set
    typedef struct packed {
        logic        ok;
        logic [31:0] mult;
        logic [5:0]  shift;
        logic        add;
    } magic_t;

    logic [31:0] divisor_q[$];     // requests waiting for the driver
    magic_t      magic_q[$];       // expected results in request order
    int          n_errors;
    bit          stim_done;
    bit          hold_sender;      // sender pauses until the pipe drains
    bit          hold_recv;        // receiver long hold-off
    bit          s_acc;            // request accepted at the last rising edge
    int          burst_left;
    int          gap_left;

    udiv32_magic_number_gen dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_divisor    (s_divisor),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_valid_res  (m_valid_res),
        .m_multiplier (m_multiplier),
        .m_post_shift (m_post_shift),
        .m_add_form   (m_add_form)
    );

    // magicu2 search done in 64-bit arithmetic
    function automatic magic_t calc_magic(logic [31:0] dv);
        magic_t      res;
        logic [63:0] d;
        logic [63:0] nc;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] q2;
        logic [63:0] r2;
        logic [63:0] delta;
        logic [63:0] two31;
        logic [63:0] m32;
        int          p;
        bit          is_add;
        res = '0;
        if (dv < 2)
            return res;
        d     = {32'd0, dv};
        two31 = 64'h8000_0000;
        m32   = 64'hFFFF_FFFF;
        nc    = m32 - (((m32 + 1) - d) % d);
        p     = 31;
        q1    = two31 / nc;
        r1    = two31 % nc;
        q2    = (two31 - 1) / d;
        r2    = (two31 - 1) % d;
        is_add = 0;
        forever begin
            p++;
            if (r1 >= nc - r1) begin
                q1 = ((q1 << 1) + 1) & m32;
                r1 = ((r1 << 1) - nc) & m32;
            end else begin
                q1 = (q1 << 1) & m32;
                r1 = (r1 << 1) & m32;
            end
            if (r2 + 1 >= d - r2) begin
                if (q2 >= two31 - 1)
                    is_add = 1;
                q2 = ((q2 << 1) + 1) & m32;
                r2 = ((r2 << 1) + 1 - d) & m32;
            end else begin
                if (q2 >= two31)
                    is_add = 1;
                q2 = (q2 << 1) & m32;
                r2 = ((r2 << 1) + 1) & m32;
            end
            delta = (d - 1 - r2) & m32;
            if (!(p < 64 && (q1 < delta || (q1 == delta && r1 == 0))))
                break;
        end
        res.ok    = 1'b1;
        res.mult  = q2[31:0] + 32'd1;
        res.shift = 6'(p - 32);
        if (is_add && res.shift > 0)
            res.shift = res.shift - 6'd1;
        res.add = is_add;
        return res;
    endfunction

    // random divisor: mostly spread over bit widths, some powers of two and edges
    function automatic logic [31:0] rand_divisor();
        logic [31:0] v;
        int          w;
        case ($urandom_range(0, 9))
            0: v = 32'd1 << $urandom_range(0, 31);
            1: v = $urandom_range(0, 3);
            2: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: v = $urandom;
            default: begin
                w = $urandom_range(1, 32);
                v = $urandom;
                if (w < 32)
                    v = v & ((32'd1 << w) - 1);
            end
        endcase
        return v;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // request list: directed edges first, then random
    initial begin
        logic [31:0] dir_list[$];
        dir_list = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd7, 32'd10,
                     32'd641, 32'd1000, 32'h8000_0000, 32'h8000_0001,
                     32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'd65536, 32'd65537,
                     32'd125, 32'd14, 32'd19, 32'd3_000_000_000};
        foreach (dir_list[i])
            divisor_q.push_back(dir_list[i]);
        repeat (650)
            divisor_q.push_back(rand_divisor());
    end

    // reset, receiver hold-off and sender drain pause
    initial begin
        aresetn     = 1'b0;
        hold_sender = 1'b0;
        hold_recv   = 1'b0;
        stim_done   = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // long receiver stall early so the pipe fills and s_ready drops
        repeat (30) @(posedge aclk);
        hold_recv = 1'b1;
        repeat (300) @(posedge aclk);
        hold_recv = 1'b0;
        // sender pauses until every result is back
        wait (divisor_q.size() < 400);
        hold_sender = 1'b1;
        wait (magic_q.size() == 0 && !s_valid);
        hold_sender = 1'b0;
        wait (divisor_q.size() == 0 && !s_valid);
        stim_done = 1'b1;
    end

    // driver: bursts of requests with random gaps, changes on falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_divisor  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_acc) begin
            // previous request taken at the last rising edge or none pending
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (hold_sender || divisor_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_valid   <= 1'b1;
                s_divisor <= divisor_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                               : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern plus the long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_recv) begin
            m_ready <= 1'b0;
        end else if (magic_q.size() > 600 || divisor_q.size() % 97 < 30) begin
            // stretch with no stalls
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: predict on request, check on result
    always @(posedge aclk) begin
        magic_t exp_m;
        if (!aresetn) begin
            n_errors <= 0;
            s_acc    <= 1'b0;
        end else begin
            s_acc <= s_valid && s_ready;
            if (s_valid && s_ready)
                magic_q.push_back(calc_magic(s_divisor));
            if (m_valid && m_ready) begin
                if (magic_q.size() == 0) begin
                    $display("%0t: unexpected result mult=%h", $time, m_multiplier);
                    n_errors <= n_errors + 1;
                end else begin
                    exp_m = magic_q.pop_front();
                    if (exp_m !== {m_valid_res, m_multiplier, m_post_shift, m_add_form}) begin
                        $display("%0t: mismatch exp ok=%b mult=%h shift=%0d add=%b",
                                 $time, exp_m.ok, exp_m.mult, exp_m.shift, exp_m.add);
                        $display("%0t:          got ok=%b mult=%h shift=%0d add=%b",
                                 $time, m_valid_res, m_multiplier, m_post_shift,
                                 m_add_form);
                        n_errors <= n_errors + 1;
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (magic_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (n_errors == 0 && magic_q.size() == 0)
            $display("tb_udiv32_magic_number_gen: PASS");
        else
            $display("tb_udiv32_magic_number_gen: FAIL");
        $finish;
    end

    // timeout
    initial begin
        #2_000_000;
        $display("tb_udiv32_magic_number_gen: FAIL");
        $finish;
    end

endmodule
